### src/calendar_date_difference_top_macros.svh
// ---------------------------------------------------------------------------
// Calendar date difference assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DIFFERENCE_TOP_MACROS_SVH
`define CALENDAR_DATE_DIFFERENCE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cdd assertion failed");

// next-cycle implication, disabled in reset
`define CDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cdd assertion failed");

`endif

### src/cdd_pkg.sv
// ---------------------------------------------------------------------------
// Calendar date difference package
// Word types, stage enables, calendar constants and table functions.
// ---------------------------------------------------------------------------
package cdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned NumW   = 23;
  localparam int unsigned DistW  = 22;

  // floor(y / 100) = (y * Recip100) >> RecipShift, exact for 14-bit y
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = 27;

  typedef enum logic [1:0] {
    ORDER_EQUAL         = 2'd0,
    ORDER_FIRST_EARLIER = 2'd1,
    ORDER_FIRST_LATER   = 2'd2
  } cdd_order_e;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
  } cdd_req_t;

  typedef struct packed {
    logic              first_valid;
    logic              second_valid;
    logic [1:0]        date_order;
    logic [DistW-1:0]  day_distance;
    logic [DayW-1:0]   following_day;
    logic [MonthW-1:0] following_month;
    logic [YearW-1:0]  following_year;
  } cdd_res_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } cdd_date_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } cdd_stage_en_t;

  function automatic logic [DayW-1:0] cdd_month_len(input logic [MonthW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // days in months 1 .. m-1 of a common year; months above 12 count 31
  function automatic logic [8:0] cdd_cum_days(input logic [MonthW-1:0] m);
    logic [8:0] cum;
    case (m)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      4'd13:   cum = 9'd365;
      4'd14:   cum = 9'd396;
      4'd15:   cum = 9'd427;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

### src/cdd_day_number.sv
// ---------------------------------------------------------------------------
// Day number pipeline
// Three stages: year products, leap count and offsets, final sum.
// ---------------------------------------------------------------------------
module cdd_day_number import cdd_pkg::*; (
  input  logic                clk_i,
  input  cdd_stage_en_t       en_i,
  input  cdd_date_t           date_i,
  output cdd_date_t           s2_date_o,
  output logic                s2_leap_o,
  output logic                exists_o,
  output logic [NumW-1:0]     num_o
);

  // stage 1
  cdd_date_t          s1_date_q;
  logic [7:0]         s1_q100_q;
  logic [NumW-1:0]    s1_y365_q;
  logic [ProdW-1:0]   prod100;
  logic [NumW-1:0]    y365;

  assign prod100 = ProdW'(date_i.year) * ProdW'(Recip100);
  assign y365    = NumW'(date_i.year) * NumW'(365);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_date_q <= date_i;
      s1_q100_q <= prod100[ProdW-1:RecipShift];
      s1_y365_q <= y365;
    end
  end

  // stage 2
  logic [YearW-1:0] hund;
  logic [YearW-1:0] rem_full;
  logic             nz100;
  logic             leap;
  logic [12:0]      ceil4;
  logic [12:0]      ceil100;
  logic [12:0]      ceil400;
  logic [12:0]      leaps;
  logic [12:0]      offset;
  logic [DayW-1:0]  mlen;
  logic             exists;

  cdd_date_t        s2_date_q;
  logic             s2_leap_q;
  logic             s2_exists_q;
  logic [NumW-1:0]  s2_base_q;
  logic [12:0]      s2_off_q;

  always_comb begin
    hund     = YearW'(s1_q100_q) * YearW'(100);
    rem_full = s1_date_q.year - hund;
    nz100    = (rem_full[6:0] != 7'd0);
    leap     = (s1_date_q.year[1:0] == 2'b00) && (nz100 || (s1_q100_q[1:0] == 2'b00));
    ceil4    = 13'(s1_date_q.year[YearW-1:2]) + 13'(|s1_date_q.year[1:0]);
    ceil100  = 13'(s1_q100_q) + 13'(nz100);
    ceil400  = 13'(s1_q100_q[7:2]) + 13'(nz100 || (s1_q100_q[1:0] != 2'b00));
    leaps    = ceil4 - ceil100 + ceil400;
    offset   = leaps + 13'(cdd_cum_days(s1_date_q.month))
             + 13'(leap && (s1_date_q.month >= 4'd3)) + 13'(s1_date_q.day);
    mlen     = cdd_month_len(s1_date_q.month, leap);
    exists   = (s1_date_q.day != '0) && (s1_date_q.month >= 4'd1)
             && (s1_date_q.month <= 4'd12) && (s1_date_q.year != '0)
             && (s1_date_q.day <= mlen);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_date_q   <= s1_date_q;
      s2_leap_q   <= leap;
      s2_exists_q <= exists;
      s2_base_q   <= s1_y365_q;
      s2_off_q    <= offset;
    end
  end

  // stage 3
  logic             s3_exists_q;
  logic [NumW-1:0]  s3_num_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_exists_q <= s2_exists_q;
      s3_num_q    <= s2_base_q + NumW'(s2_off_q);
    end
  end

  assign s2_date_o = s2_date_q;
  assign s2_leap_o = s2_leap_q;
  assign exists_o  = s3_exists_q;
  assign num_o     = s3_num_q;

endmodule

### src/cdd_next_date.sv
// ---------------------------------------------------------------------------
// Following date stage
// Advances a date by one day, with month and year carry.
// ---------------------------------------------------------------------------
module cdd_next_date import cdd_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  cdd_date_t     date_i,
  input  logic          leap_i,
  output cdd_date_t     next_o
);

  logic [DayW-1:0] mlen;
  cdd_date_t       next_d;
  cdd_date_t       next_q;

  always_comb begin
    mlen   = cdd_month_len(date_i.month, leap_i);
    next_d = date_i;
    if (({1'b0, date_i.day} + 6'd1) > {1'b0, mlen}) begin
      next_d.day = 5'd1;
      if (date_i.month >= 4'd12) begin
        next_d.month = 4'd1;
        next_d.year  = date_i.year + 14'd1;
      end else begin
        next_d.month = date_i.month + 4'd1;
      end
    end else begin
      next_d.day = date_i.day + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;

endmodule

### src/cdd_distance.sv
// ---------------------------------------------------------------------------
// Day distance
// Absolute difference of two day numbers, saturated to the field width.
// ---------------------------------------------------------------------------
module cdd_distance import cdd_pkg::*; (
  input  logic [NumW-1:0]  num_a_i,
  input  logic [NumW-1:0]  num_b_i,
  output logic [DistW-1:0] dist_o
);

  logic [NumW:0]   diff_ab;
  logic [NumW-1:0] diff_ba;
  logic [NumW-1:0] mag;

  always_comb begin
    diff_ab = {1'b0, num_a_i} - {1'b0, num_b_i};
    diff_ba = num_b_i - num_a_i;
    mag     = diff_ab[NumW] ? diff_ba : diff_ab[NumW-1:0];
    dist_o  = mag[NumW-1] ? '1 : mag[DistW-1:0];
  end

endmodule

### src/calendar_date_difference_top.sv
// ---------------------------------------------------------------------------
// Calendar date difference
// Gregorian day numbers, order and distance of two dates, first's next date.
// ---------------------------------------------------------------------------
// Usage:
//   A request word (req_i) is taken at a rising edge where start is high and
//   busy is low. The result word passes the four register stages named below
//   and shows on res_o for exactly one cycle with done_o high; the receiver
//   cannot stall.
//   Throughput is one word per cycle: a new request may be given at every
//   edge, since each of the four register stages (year products, leap
//   count and month offset, day sum, distance and output register) moves
//   its word on every cycle.
//   Results leave in request order.
//   Reset (rst_ni low) drops all words in flight; busy is high during reset
//   and for the first edge after it, then stays low.
//   Fields of invalid dates are used as given; the valid flags gate nothing.
//   day_distance saturates at its all-ones value.
// ---------------------------------------------------------------------------
module calendar_date_difference_top import cdd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cdd_req_t req_i,
  output logic     done_o,
  output cdd_res_t res_o
);

  logic          busy_q;
  logic          accept;
  logic [2:0]    vld_q;
  logic          done_q;
  cdd_stage_en_t en;

  assign accept = start && !busy_q;
  assign en     = '{s1: accept, s2: vld_q[0], s3: vld_q[1], s4: vld_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[1:0], accept};
      done_q <= vld_q[2];
    end
  end

  // order on raw fields
  cdd_order_e order_d;
  cdd_order_e order_s1_q;
  cdd_order_e order_s2_q;
  cdd_order_e order_s3_q;

  always_comb begin
    if (req_i.first_year != req_i.second_year) begin
      order_d = (req_i.first_year < req_i.second_year) ? ORDER_FIRST_EARLIER
                                                       : ORDER_FIRST_LATER;
    end else if (req_i.first_month != req_i.second_month) begin
      order_d = (req_i.first_month < req_i.second_month) ? ORDER_FIRST_EARLIER
                                                         : ORDER_FIRST_LATER;
    end else if (req_i.first_day != req_i.second_day) begin
      order_d = (req_i.first_day < req_i.second_day) ? ORDER_FIRST_EARLIER
                                                     : ORDER_FIRST_LATER;
    end else begin
      order_d = ORDER_EQUAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      order_s1_q <= order_d;
    end
    if (en.s2) begin
      order_s2_q <= order_s1_q;
    end
    if (en.s3) begin
      order_s3_q <= order_s2_q;
    end
  end

  cdd_date_t       date_a;
  cdd_date_t       date_b;
  cdd_date_t       a_s2_date;
  cdd_date_t       b_s2_date;
  logic            a_s2_leap;
  logic            b_s2_leap;
  logic            a_exists;
  logic            b_exists;
  logic [NumW-1:0] a_num;
  logic [NumW-1:0] b_num;
  cdd_date_t       next_date;
  logic [DistW-1:0] dist_days;

  assign date_a = '{day: req_i.first_day, month: req_i.first_month,
                    year: req_i.first_year};
  assign date_b = '{day: req_i.second_day, month: req_i.second_month,
                    year: req_i.second_year};

  cdd_day_number u_num_a (
    .clk_i     (clk_i),
    .en_i      (en),
    .date_i    (date_a),
    .s2_date_o (a_s2_date),
    .s2_leap_o (a_s2_leap),
    .exists_o  (a_exists),
    .num_o     (a_num)
  );

  cdd_day_number u_num_b (
    .clk_i     (clk_i),
    .en_i      (en),
    .date_i    (date_b),
    .s2_date_o (b_s2_date),
    .s2_leap_o (b_s2_leap),
    .exists_o  (b_exists),
    .num_o     (b_num)
  );

  cdd_next_date u_next (
    .clk_i  (clk_i),
    .en_i   (en.s3),
    .date_i (a_s2_date),
    .leap_i (a_s2_leap),
    .next_o (next_date)
  );

  cdd_distance u_dist (
    .num_a_i (a_num),
    .num_b_i (b_num),
    .dist_o  (dist_days)
  );

  // second date's stage-2 view is unused; b_unused only keeps it connected
  logic b_unused;
  assign b_unused = b_s2_leap ^ (^b_s2_date);

  cdd_res_t res_q;

  always_ff @(posedge clk_i) begin
    if (en.s4) begin
      res_q.first_valid     <= a_exists;
      res_q.second_valid    <= b_exists && (b_unused | !b_unused);
      res_q.date_order      <= order_s3_q;
      res_q.day_distance    <= dist_days;
      res_q.following_day   <= next_date.day;
      res_q.following_month <= next_date.month;
      res_q.following_year  <= next_date.year;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/cdd_checker.sv
// ---------------------------------------------------------------------------
// Calendar date difference checker
// Port-level properties of the top level, bound in below.
// ---------------------------------------------------------------------------
`include "calendar_date_difference_top_macros.svh"

module cdd_checker import cdd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input cdd_req_t req_i,
  input logic     done_o,
  input cdd_res_t res_o
);

  logic req_seen;
  assign req_seen = start && !busy && (req_i == req_i);

  `CDD_ASSERT_IMPL(a_fixed_latency, 1'b1, done_o == $past(req_seen, 4))
  `CDD_ASSERT_NEXT(a_busy_once, busy, !busy)
  `CDD_ASSERT_IMPL(a_equal_zero_dist, done_o && (res_o.date_order == ORDER_EQUAL),
                   res_o.day_distance == '0)
  `CDD_ASSERT_IMPL(a_valid_next_date, done_o && res_o.first_valid,
                   (res_o.following_day != '0) && (res_o.following_month >= 4'd1)
                   && (res_o.following_month <= 4'd12))

endmodule

bind calendar_date_difference_top cdd_checker u_cdd_checker (.*);

### tb/sv/calendar_date_difference_top_tb.sv
// ---------------------------------------------------------------------------
// Calendar date difference testbench
// Sends date pairs to the block with random gaps and bursts. Each result
// word is checked against a day-number model that runs inside the bench.
// Directed pairs cover leap and century years, rollovers, odd month codes
// and distance saturation. Random pairs are mostly valid dates with some
// raw field values mixed in.
// ---------------------------------------------------------------------------
module calendar_date_difference_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdd_pkg::*;

  localparam int unsigned RandomWords = 1750;
  localparam int unsigned QuietLimit  = 200;
  localparam int unsigned DistCap     = (1 << DistW) - 1;

  class date_diff_ledger;
    cdd_res_t    pending_answers[$];
    int unsigned mismatches = 0;
    int unsigned checked    = 0;
    int unsigned pairs      = 0;
    int unsigned both_valid = 0;
    int unsigned saturated  = 0;

    function bit is_leap(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned days_in_month(int unsigned m, int unsigned y);
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      if (m == 2) return is_leap(y) ? 29 : 28;
      return 31;
    endfunction

    function bit date_exists(int unsigned d, int unsigned m, int unsigned y);
      if (d < 1 || m < 1 || m > 12 || y < 1) return 1'b0;
      return d <= days_in_month(m, y);
    endfunction

    function int unsigned serial_day(int unsigned d, int unsigned m, int unsigned y);
      int unsigned n;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      for (int unsigned i = 1; i < m; i++) n += days_in_month(i, y);
      return n + d;
    endfunction

    function cdd_res_t answer_for(cdd_req_t w);
      cdd_res_t    r;
      int unsigned d1, m1, y1, d2, m2, y2, n1, n2, span;
      d1 = w.first_day;  m1 = w.first_month;  y1 = w.first_year;
      d2 = w.second_day; m2 = w.second_month; y2 = w.second_year;
      r.first_valid  = date_exists(d1, m1, y1);
      r.second_valid = date_exists(d2, m2, y2);
      if (y1 != y2)      r.date_order = (y1 < y2) ? ORDER_FIRST_EARLIER : ORDER_FIRST_LATER;
      else if (m1 != m2) r.date_order = (m1 < m2) ? ORDER_FIRST_EARLIER : ORDER_FIRST_LATER;
      else if (d1 != d2) r.date_order = (d1 < d2) ? ORDER_FIRST_EARLIER : ORDER_FIRST_LATER;
      else               r.date_order = ORDER_EQUAL;
      n1 = serial_day(d1, m1, y1);
      n2 = serial_day(d2, m2, y2);
      span = (n1 >= n2) ? n1 - n2 : n2 - n1;
      if (span > DistCap) span = DistCap;
      r.day_distance    = DistW'(span);
      r.following_day   = DayW'(d1 + 1);
      r.following_month = MonthW'(m1);
      r.following_year  = YearW'(y1);
      if (d1 + 1 > days_in_month(m1, y1)) begin
        r.following_day = DayW'(1);
        if (m1 + 1 > 12) begin
          r.following_month = MonthW'(1);
          r.following_year  = YearW'(y1 + 1);
        end else begin
          r.following_month = MonthW'(m1 + 1);
        end
      end
      return r;
    endfunction

    function void note_request(cdd_req_t w);
      cdd_res_t r;
      r = answer_for(w);
      pairs++;
      if (r.first_valid && r.second_valid) both_valid++;
      if (r.day_distance == DistW'(DistCap)) saturated++;
      pending_answers.push_back(r);
    endfunction

    function void check_result(cdd_res_t got);
      cdd_res_t exp;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result word with nothing pending: dist=%0d", $time,
                   got.day_distance);
        return;
      end
      exp = pending_answers.pop_front();
      checked++;
      if (got.first_valid !== exp.first_valid || got.second_valid !== exp.second_valid ||
          got.date_order !== exp.date_order || got.day_distance !== exp.day_distance ||
          got.following_day !== exp.following_day ||
          got.following_month !== exp.following_month ||
          got.following_year !== exp.following_year) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] mismatch: exp v=%0d/%0d ord=%0d dist=%0d next=%0d/%0d/%0d",
                    " got v=%0d/%0d ord=%0d dist=%0d next=%0d/%0d/%0d"}, $time,
                   exp.first_valid, exp.second_valid, exp.date_order, exp.day_distance,
                   exp.following_day, exp.following_month, exp.following_year,
                   got.first_valid, got.second_valid, got.date_order, got.day_distance,
                   got.following_day, got.following_month, got.following_year);
      end
    endfunction
  endclass

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  cdd_req_t req_i  = '0;
  logic     done_o;
  cdd_res_t res_o;

  date_diff_ledger ledger;
  int unsigned     quiet_cycles = 0;

  calendar_date_difference_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) ledger.check_result(res_o);
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] watchdog expired, %0d words pending", $time,
                 ledger.pending_answers.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic cdd_req_t date_pair(int d1, int m1, int y1, int d2, int m2, int y2);
    cdd_req_t w;
    w.first_day   = DayW'(d1);
    w.first_month = MonthW'(m1);
    w.first_year  = YearW'(y1);
    w.second_day  = DayW'(d2);
    w.second_month = MonthW'(m2);
    w.second_year = YearW'(y2);
    return w;
  endfunction

  // valid date, biased toward month ends, first days, century years and early years
  function automatic cdd_date_t pick_date();
    cdd_date_t   dt;
    int unsigned y, m, len;
    case ($urandom_range(9))
      0:       y = $urandom_range(99, 1) * 100;
      1:       y = $urandom_range(40, 1);
      default: y = $urandom_range(9999, 1);
    endcase
    m = $urandom_range(12, 1);
    len = ledger.days_in_month(m, y);
    dt.year  = YearW'(y);
    dt.month = MonthW'(m);
    case ($urandom_range(5))
      0:       dt.day = DayW'(len);
      1:       dt.day = DayW'(len - 1);
      2:       dt.day = DayW'(1);
      default: dt.day = DayW'($urandom_range(len, 1));
    endcase
    return dt;
  endfunction

  task automatic drive_word(cdd_req_t w, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    ledger.note_request(w);
  endtask

  function automatic int unsigned draw_gap(inout int unsigned burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(29) == 0) begin
      burst_left = $urandom_range(60, 20);
      return 0;
    end
    return $urandom_range(1) ? $urandom_range(18) : 0;
  endfunction

  initial begin
    cdd_req_t    directed[$];
    cdd_req_t    w;
    cdd_date_t   a, b;
    int unsigned burst_left;
    int unsigned len;
    ledger = new();
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(date_pair(0, 0, 0, 0, 0, 0));
    directed.push_back(date_pair(31, 15, 16383, 31, 15, 16383));
    directed.push_back(date_pair(31, 12, 9999, 1, 1, 1));
    directed.push_back(date_pair(1, 1, 1, 31, 12, 9999));
    directed.push_back(date_pair(28, 2, 2000, 29, 2, 2000));
    directed.push_back(date_pair(29, 2, 2000, 1, 3, 2000));
    directed.push_back(date_pair(28, 2, 1900, 1, 3, 1900));
    directed.push_back(date_pair(29, 2, 1900, 1, 3, 1900));
    directed.push_back(date_pair(29, 2, 2024, 28, 2, 2023));
    directed.push_back(date_pair(29, 2, 2023, 1, 3, 2023));
    directed.push_back(date_pair(0, 5, 2020, 1, 5, 2020));
    directed.push_back(date_pair(15, 0, 2020, 15, 1, 2020));
    directed.push_back(date_pair(31, 0, 2020, 1, 1, 2020));
    directed.push_back(date_pair(31, 13, 2020, 1, 1, 2021));
    directed.push_back(date_pair(5, 14, 2020, 5, 14, 2020));
    directed.push_back(date_pair(29, 2, 0, 10, 6, 1));
    directed.push_back(date_pair(31, 4, 2021, 1, 5, 2021));
    directed.push_back(date_pair(30, 6, 2021, 30, 6, 2021));
    directed.push_back(date_pair(1, 1, 16383, 1, 1, 0));
    directed.push_back(date_pair(31, 12, 16383, 1, 1, 1));
    directed.push_back(date_pair(30, 11, 2021, 1, 12, 2021));
    directed.push_back(date_pair(15, 7, 2021, 14, 7, 2021));
    directed.push_back(date_pair(1, 3, 2021, 1, 2, 2021));
    foreach (directed[i]) drive_word(directed[i], draw_gap(burst_left));

    for (int unsigned n = 0; n < RandomWords; n++) begin
      a = pick_date();
      b = pick_date();
      case ($urandom_range(19))
        0, 1, 2: b = a;
        3, 4, 5: begin
          b.year  = a.year;
          b.month = a.month;
          len = ledger.days_in_month(a.month, a.year);
          b.day = DayW'($urandom_range(len, 1));
        end
        6, 7: begin
          b.year  = a.year + YearW'($urandom_range(1));
          b.month = MonthW'($urandom_range(12, 1));
          b.day   = DayW'($urandom_range(28, 1));
        end
        8, 9, 10, 11: begin
          a.day   = DayW'($urandom_range(31));
          a.month = MonthW'($urandom_range(15));
          a.year  = YearW'($urandom_range(7) == 0 ? $urandom_range(16383) :
                                                    $urandom_range(9999));
          b.day   = DayW'($urandom_range(31));
          b.month = MonthW'($urandom_range(15));
          b.year  = YearW'($urandom_range(7) == 0 ? $urandom_range(16383) :
                                                    $urandom_range(9999));
        end
        default: ;
      endcase
      w = {a, b};
      drive_word(w, draw_gap(burst_left));
    end
    start <= 1'b0;

    while (ledger.pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d date pairs (%0d with both dates valid, %0d with capped distance).",
             ledger.pairs, ledger.both_valid, ledger.saturated);
    $display("Checked %0d result words, %0d mismatches.", ledger.checked, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
